[design/ecov_pkg.sv]
// ----------------------------------------------------------------------------
// ecov_pkg
// Shared types and constants of the exponential covariance kernel.
// ----------------------------------------------------------------------------
package ecov_pkg;

    typedef enum logic [1:0] {
        CMD_EVAL     = 2'd0,
        CMD_LD_AMP   = 2'd1,
        CMD_LD_SCALE = 2'd2,
        CMD_LD_CORR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REJECT    = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LOAD,
        B_Y,
        B_X,
        B_P,
        B_E,
        B_MUL,
        B_MUL2,
        B_EMIT
    } t_bstate;

    typedef struct packed {
        t_cmd        cmd;
        logic [1:0]  row;
        logic [1:0]  col;
        logic [15:0] value;
        logic [31:0] abs_tau;
        t_status     status;
    } t_job;

    localparam logic [61:0] LOG2E_Q30 = 62'd1549082005;
    localparam logic [46:0] Y_CLAMP   = 47'd1073741824;
    localparam logic [15:0] RESET_ONE = 16'd128;

    localparam longint unsigned ROOT_Q30 [11] = '{
        64'd0, 64'd759250125, 64'd902905651, 64'd984625594, 64'd1028218693,
        64'd1050733751, 64'd1062175491, 64'd1067942999, 64'd1070838486,
        64'd1072289173, 64'd1073015252
    };

    // 2^(-k / 2^bits) in Q.30
    function automatic longint unsigned f_pow(input int k, input int bits);
        longint unsigned v;
        v = 64'd1073741824;
        for (int b = 0; b < bits; b++) begin
            if (((k >> b) & 1) != 0) begin
                v = (v * ROOT_Q30[bits - b] + 64'd536870912) >> 30;
            end
        end
        return v;
    endfunction

endpackage

[design/ecov_front.sv]
// ----------------------------------------------------------------------------
// ecov_front
// Classifies incoming transactions: index and sign checks, lag magnitude.
// ----------------------------------------------------------------------------
module ecov_front import ecov_pkg::*; #(
    parameter int DIM = 4
) (
    input  logic [1:0]         i_cmd,
    input  logic [1:0]         i_row_index,
    input  logic [1:0]         i_col_index,
    input  logic signed [15:0] i_load_value,
    input  logic signed [31:0] i_tau,
    output t_job               o_job
);

    logic    w_row_ok;
    logic    w_corr_ok;
    logic    w_nonpos;
    t_status w_status;
    t_cmd    w_cmd;

    assign w_cmd     = t_cmd'(i_cmd);
    assign w_row_ok  = (32'(i_row_index) < 32'(DIM));
    assign w_corr_ok = w_row_ok && (i_col_index < i_row_index);
    assign w_nonpos  = i_load_value[15] || (i_load_value == 16'sd0);

    always_comb begin
        unique case (w_cmd)
            CMD_EVAL: begin
                w_status = ST_OK;
            end
            CMD_LD_AMP, CMD_LD_SCALE: begin
                if (!w_row_ok) begin
                    w_status = ST_BAD_INDEX;
                end else if (w_nonpos) begin
                    w_status = ST_REJECT;
                end else begin
                    w_status = ST_OK;
                end
            end
            default: begin
                w_status = w_corr_ok ? ST_OK : ST_BAD_INDEX;
            end
        endcase
    end

    always_comb begin
        o_job.cmd     = w_cmd;
        o_job.row     = i_row_index;
        o_job.col     = (w_cmd == CMD_LD_CORR) ? i_col_index : i_row_index;
        o_job.value   = i_load_value;
        o_job.abs_tau = i_tau[31] ? (~i_tau + 32'd1) : i_tau;
        o_job.status  = w_status;
    end

endmodule

[design/ecov_queue.sv]
// ----------------------------------------------------------------------------
// ecov_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module ecov_queue import ecov_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

[design/ecov_back.sv]
// ----------------------------------------------------------------------------
// ecov_back
// Executes jobs: table loads, per-dimension exponential, entry emission.
// ----------------------------------------------------------------------------
module ecov_back import ecov_pkg::*; #(
    parameter int DIM            = 4,
    parameter int EXP_TABLE_BITS = 6
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_diag_only,
    input  logic         i_q_empty,
    input  t_job         i_job,
    output logic         o_pop,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic [1:0]   o_out_row,
    output logic [1:0]   o_out_col,
    output logic [47:0]  o_cov_value,
    output logic [1:0]   o_status,
    output logic         o_last
);

    localparam int IW    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int NTRI  = (DIM > 1) ? (DIM * (DIM - 1)) / 2 : 1;
    localparam int TW    = (NTRI > 1) ? $clog2(NTRI) : 1;
    localparam int TSIZE = 1 << EXP_TABLE_BITS;

    logic [30:0] w_pow [TSIZE];
    for (genvar k = 0; k < TSIZE; k++) begin : g_pow
        localparam longint unsigned PV = f_pow(k, EXP_TABLE_BITS);
        assign w_pow[k] = PV[30:0];
    end

    t_bstate r_state, n_state;
    t_job    r_job;
    logic [15:0] r_amp  [DIM];
    logic [15:0] r_scl  [DIM];
    logic [15:0] r_corr [NTRI];
    logic [30:0] r_e    [DIM];
    logic [IW-1:0] r_i, r_j;
    logic        r_diag;
    logic [30:0] r_y;
    logic [22:0] r_x;
    logic [30:0] r_p;
    logic [30:0] r_ea;
    logic [61:0] r_prod;
    logic [15:0] r_cv;

    logic        r_out_valid;
    logic [1:0]  r_out_row, r_out_col, r_out_status;
    logic [47:0] r_out_cov;
    logic        r_out_last;

    logic          w_slot;
    logic          w_load_out;
    logic          w_emit_out;
    logic          w_entry_last;
    logic          w_end_diag;
    logic [IW-1:0] w_ld_idx;
    logic [TW-1:0] w_ld_tri;
    logic [TW-1:0] w_rd_tri;
    logic [IW-1:0] w_e_addr;
    logic [46:0]   w_yprod;
    logic [63:0]   w_xprod;
    logic [63:0]   w_xr;
    logic [46:0]   w_eprod;
    logic [61:0]   w_dsum;
    logic [15:0]   w_mag;
    logic [61:0]   w_mprod;
    logic [33:0]   w_m;
    logic [47:0]   w_cov;

    assign w_slot   = !r_out_valid || !i_out_stall;
    assign w_ld_idx = IW'(r_job.row);
    assign w_ld_tri = TW'((32'(r_job.row) * (32'(r_job.row) - 1)) / 2 + 32'(r_job.col));
    assign w_rd_tri = TW'((32'(r_i) * (32'(r_i) - 1)) / 2 + 32'(r_j));
    assign w_e_addr = (r_state == B_MUL) ? r_i : r_j;

    assign w_end_diag   = (r_i == IW'(DIM - 1));
    assign w_entry_last = r_diag ? (w_end_diag && (i_diag_only || DIM == 1))
                                 : (w_end_diag && (r_j == r_i - IW'(1)));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_job.cmd == CMD_EVAL) ? B_Y : B_LOAD;
                end
            end
            B_LOAD: begin
                if (w_slot) begin
                    n_state = B_IDLE;
                end
            end
            B_Y:    n_state = B_X;
            B_X:    n_state = B_P;
            B_P:    n_state = B_E;
            B_E:    n_state = w_end_diag ? B_MUL : B_Y;
            B_MUL:  n_state = B_MUL2;
            B_MUL2: n_state = B_EMIT;
            B_EMIT: begin
                if (w_slot) begin
                    n_state = w_entry_last ? B_IDLE : B_MUL;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = (r_state == B_IDLE) && !i_q_empty;
        w_load_out = (r_state == B_LOAD) && w_slot;
        w_emit_out = (r_state == B_EMIT) && w_slot;
    end

    assign w_yprod = 47'(r_scl[r_i]) * 47'(r_job.abs_tau);
    assign w_xprod = 64'(r_y) * 64'(LOG2E_Q30);
    assign w_xr    = (w_xprod + (64'd1 << 37)) >> 38;
    assign w_eprod = 47'(r_amp[r_i]) * 47'(r_p);
    assign w_dsum  = (r_prod + (62'd1 << 29)) >> 30;
    assign w_mag   = r_cv[15] ? (~r_cv + 16'd1) : r_cv;
    assign w_mprod = 62'(r_prod[61:16]) * 62'(w_mag);
    assign w_m     = 34'((w_mprod + (62'd1 << 27)) >> 28);

    always_comb begin
        if (r_diag) begin
            w_cov = 48'(w_dsum);
        end else if (r_cv[15]) begin
            w_cov = -(48'(w_m));
        end else begin
            w_cov = 48'(w_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_out_valid <= 1'b0;
            for (int d = 0; d < DIM; d++) begin
                r_amp[d] <= RESET_ONE;
                r_scl[d] <= RESET_ONE;
            end
            for (int t = 0; t < NTRI; t++) begin
                r_corr[t] <= 16'd0;
            end
        end else begin
            r_state <= n_state;
            if (w_load_out || w_emit_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_load_out && r_job.status == ST_OK) begin
                unique case (r_job.cmd)
                    CMD_LD_AMP:   r_amp[w_ld_idx]  <= r_job.value;
                    CMD_LD_SCALE: r_scl[w_ld_idx]  <= r_job.value;
                    CMD_LD_CORR:  r_corr[w_ld_tri] <= r_job.value;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_i    <= '0;
            r_j    <= '0;
            r_diag <= 1'b1;
        end
        unique case (r_state)
            B_Y: r_y <= (w_yprod > Y_CLAMP) ? Y_CLAMP[30:0] : w_yprod[30:0];
            B_X: r_x <= w_xr[22:0];
            B_P: r_p <= (r_x[22:16] >= 7'd31) ? 31'd0
                        : (w_pow[r_x[15:16-EXP_TABLE_BITS]] >> r_x[20:16]);
            B_E: begin
                r_e[r_i] <= w_eprod[44:14];
                r_i      <= w_end_diag ? '0 : r_i + IW'(1);
            end
            B_MUL: r_ea <= r_e[w_e_addr];
            B_MUL2: begin
                r_prod <= 62'(r_ea) * 62'(r_e[w_e_addr]);
                r_cv   <= r_corr[w_rd_tri];
            end
            B_EMIT: begin
                if (w_slot && !w_entry_last) begin
                    if (r_diag && w_end_diag) begin
                        r_diag <= 1'b0;
                        r_i    <= IW'(1);
                        r_j    <= '0;
                    end else if (r_diag) begin
                        r_i <= r_i + IW'(1);
                        r_j <= r_i + IW'(1);
                    end else if (r_j == r_i - IW'(1)) begin
                        r_i <= r_i + IW'(1);
                        r_j <= '0;
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
            end
            default: ;
        endcase
        if (w_load_out) begin
            r_out_row    <= r_job.row;
            r_out_col    <= r_job.col;
            r_out_cov    <= '0;
            r_out_status <= r_job.status;
            r_out_last   <= 1'b1;
        end else if (w_emit_out) begin
            r_out_row    <= 2'(r_i);
            r_out_col    <= 2'(r_diag ? r_i : r_j);
            r_out_cov    <= w_cov;
            r_out_status <= ST_OK;
            r_out_last   <= w_entry_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_cov_value = r_out_cov;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

    a_nonlast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> r_state != B_IDLE)
        else $error("non-final entry pending with idle sequencer");

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != ST_OK |-> r_out_last)
        else $error("error status on non-final result");

    a_lower_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_EMIT && !r_diag |-> r_j < r_i)
        else $error("off-diagonal entry outside lower triangle");

endmodule

[design/exponential_covariance_kernel_core.sv]
// ----------------------------------------------------------------------------
// exponential_covariance_kernel_core
// Multivariate exponential covariance kernel, lower triangle, Q32.16 output.
//
// Input channel (i_in_valid / o_in_stall) takes evaluate and table-load
// transactions. A front stage checks indexes and signs and queues the job
// (two entries); a back sequencer executes jobs one at a time.
// Loads give one result. An evaluate computes the exponential for each
// dimension in turn (scale multiply, log2(e) multiply, table lookup and
// shift, amplitude multiply), then per entry fetches the factors, forms
// the product and emits it: DIM entries, or DIM*(DIM+1)/2 when not
// diagonal_only.
// Results leave through an output register (o_out_valid / i_out_stall);
// o_last marks the final result of a transaction. A stall holds the
// register and pauses the sequencer; the queue keeps accepting.
// i_cfg_we writes diagonal_only (reset 1). Reset restores amplitudes and
// scales to 1.0, correlations to zero, and empties queue and output.
// ----------------------------------------------------------------------------
module exponential_covariance_kernel_core import ecov_pkg::*; #(
    parameter int DIM            = 4,
    parameter int EXP_TABLE_BITS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic [1:0]         i_row_index,
    input  logic [1:0]         i_col_index,
    input  logic signed [15:0] i_load_value,
    input  logic signed [31:0] i_tau,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_out_row,
    output logic [1:0]         o_out_col,
    output logic signed [47:0] o_cov_value,
    output logic [1:0]         o_status,
    output logic               o_last
);

    logic  r_diag_only;
    t_job  w_front_job;
    t_job  w_q_job;
    logic  w_full;
    logic  w_empty;
    logic  w_pop;
    logic [47:0] w_cov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diag_only <= 1'b1;
        end else if (i_cfg_we) begin
            r_diag_only <= i_cfg_data;
        end
    end

    ecov_front #(.DIM(DIM)) u_front (
        .i_cmd        (i_cmd),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_load_value (i_load_value),
        .i_tau        (i_tau),
        .o_job        (w_front_job)
    );

    ecov_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_job   (w_q_job)
    );

    ecov_back #(.DIM(DIM), .EXP_TABLE_BITS(EXP_TABLE_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_diag_only (r_diag_only),
        .i_q_empty   (w_empty),
        .i_job       (w_q_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_cov_value (w_cov),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    assign o_in_stall  = w_full;
    assign o_cov_value = w_cov;

endmodule
